@@ rtl/saa_pkg.sv @@
// Package with shared constants, types and a helper function for sensor axis alignment.
`timescale 1ns / 1ps

package saa_pkg;

  // Sample and coefficient widths.
  localparam int SampleW = 16;
  localparam int CoefW = 16;
  localparam int RowW = 3 * CoefW;
  localparam int CoefFracBits = 14;

  // Product and row sum widths: three full-range products need two guard bits.
  localparam int ProdW = 2 * SampleW;
  localparam int SumW = ProdW + 2;
  localparam int ShiftW = SumW - CoefFracBits;

  // Configuration register indexes.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_ALIGN_EN = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW_X = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROW_Y = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROW_Z = 2'd3;

  // Reset values: identity matrix in Q2.14.
  localparam logic [RowW-1:0] ROW_X_RESET = 48'h0000_0000_4000;
  localparam logic [RowW-1:0] ROW_Y_RESET = 48'h0000_4000_0000;
  localparam logic [RowW-1:0] ROW_Z_RESET = 48'h4000_0000_0000;

  // Mounting orientation codes.
  localparam int OrientW = 3;
  localparam logic [OrientW-1:0] ORIENT_CW0 = 3'd0;
  localparam logic [OrientW-1:0] ORIENT_CW90 = 3'd1;
  localparam logic [OrientW-1:0] ORIENT_CW180 = 3'd2;
  localparam logic [OrientW-1:0] ORIENT_CW270 = 3'd3;
  localparam logic [OrientW-1:0] ORIENT_CW0_FLIP = 3'd4;
  localparam logic [OrientW-1:0] ORIENT_CW90_FLIP = 3'd5;
  localparam logic [OrientW-1:0] ORIENT_CW180_FLIP = 3'd6;
  localparam logic [OrientW-1:0] ORIENT_CW270_FLIP = 3'd7;

  typedef logic signed [SampleW-1:0] sample_t;

  // One three-axis vector with its valid bit.
  typedef struct packed {
    logic    valid;
    sample_t x;
    sample_t y;
    sample_t z;
  } vec_t;

  // Negation that maps the most negative value to the most positive one.
  function automatic sample_t neg_sat(input sample_t v);
    sample_t r;
    if (v == {1'b1, {(SampleW-1){1'b0}}}) begin
      r = {1'b0, {(SampleW-1){1'b1}}};
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

@@ rtl/saa_remap.sv @@
// First pipeline stage: axis swap and saturating negation by mounting orientation.
`timescale 1ns / 1ps

module saa_remap (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  saa_pkg::sample_t              in_x,
  input  saa_pkg::sample_t              in_y,
  input  saa_pkg::sample_t              in_z,
  input  logic [saa_pkg::OrientW-1:0]   in_orient,
  output saa_pkg::vec_t                 out_vec
);

  saa_pkg::sample_t x_nxt, y_nxt, z_nxt;
  saa_pkg::sample_t x_r, y_r, z_r;
  logic             valid_r;

  // Select and negate axes for the orientation code.
  always_comb begin
    unique case (in_orient)
      saa_pkg::ORIENT_CW0: begin
        x_nxt = in_x;
        y_nxt = in_y;
        z_nxt = in_z;
      end
      saa_pkg::ORIENT_CW90: begin
        x_nxt = in_y;
        y_nxt = saa_pkg::neg_sat(in_x);
        z_nxt = in_z;
      end
      saa_pkg::ORIENT_CW180: begin
        x_nxt = saa_pkg::neg_sat(in_x);
        y_nxt = saa_pkg::neg_sat(in_y);
        z_nxt = in_z;
      end
      saa_pkg::ORIENT_CW270: begin
        x_nxt = saa_pkg::neg_sat(in_y);
        y_nxt = in_x;
        z_nxt = in_z;
      end
      saa_pkg::ORIENT_CW0_FLIP: begin
        x_nxt = saa_pkg::neg_sat(in_x);
        y_nxt = in_y;
        z_nxt = saa_pkg::neg_sat(in_z);
      end
      saa_pkg::ORIENT_CW90_FLIP: begin
        x_nxt = in_y;
        y_nxt = in_x;
        z_nxt = saa_pkg::neg_sat(in_z);
      end
      saa_pkg::ORIENT_CW180_FLIP: begin
        x_nxt = in_x;
        y_nxt = saa_pkg::neg_sat(in_y);
        z_nxt = saa_pkg::neg_sat(in_z);
      end
      saa_pkg::ORIENT_CW270_FLIP: begin
        x_nxt = saa_pkg::neg_sat(in_y);
        y_nxt = saa_pkg::neg_sat(in_x);
        z_nxt = saa_pkg::neg_sat(in_z);
      end
      default: begin
        x_nxt = in_x;
        y_nxt = in_y;
        z_nxt = in_z;
      end
    endcase
  end

  // Valid bit is control state and resets; the vector does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign out_vec = '{valid: valid_r, x: x_r, y: y_r, z: z_r};

endmodule

@@ rtl/saa_row.sv @@
// One matrix row: registered products, registered sum, then rounding and saturation.
`timescale 1ns / 1ps

module saa_row (
  input  logic                        clk,
  input  logic [saa_pkg::RowW-1:0]    coef_row,
  input  saa_pkg::sample_t            vec_x,
  input  saa_pkg::sample_t            vec_y,
  input  saa_pkg::sample_t            vec_z,
  output saa_pkg::sample_t            result
);

  localparam int FracW = saa_pkg::CoefFracBits;
  localparam int SumW = saa_pkg::SumW;
  localparam int ShiftW = saa_pkg::ShiftW;
  localparam int SampleW = saa_pkg::SampleW;
  localparam int CoefW = saa_pkg::CoefW;
  localparam int ProdW = saa_pkg::ProdW;

  localparam logic signed [ShiftW-1:0] SatMax = ShiftW'(32767);
  localparam logic signed [ShiftW-1:0] SatMin = -ShiftW'(32768);
  localparam logic signed [SumW-1:0] RoundBias = SumW'((1 << FracW) - 1);

  logic signed [CoefW-1:0]             cx, cy, cz;
  logic signed [ProdW-1:0]             px_r, py_r, pz_r;
  logic signed [SumW-1:0]              sum_nxt, sum_r;
  logic signed [SumW-1:0]              biased;
  logic signed [ShiftW-1:0]            shifted;

  assign cx = coef_row[CoefW-1:0];
  assign cy = coef_row[2*CoefW-1:CoefW];
  assign cz = coef_row[3*CoefW-1:2*CoefW];

  // Stage two: three independent products.
  always_ff @(posedge clk) begin
    px_r <= ProdW'(cx) * ProdW'(vec_x);
    py_r <= ProdW'(cy) * ProdW'(vec_y);
    pz_r <= ProdW'(cz) * ProdW'(vec_z);
  end

  // Stage three: row sum with sign extension to the guard width.
  assign sum_nxt = SumW'(px_r) + SumW'(py_r) + SumW'(pz_r);

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  // Divide by the fraction scale with truncation toward zero, then clamp.
  always_comb begin
    if (sum_r[SumW-1]) begin
      biased = sum_r + RoundBias;
    end else begin
      biased = sum_r;
    end
    shifted = ShiftW'(biased >>> FracW);
    priority if (shifted > SatMax) begin
      result = SatMax[SampleW-1:0];
    end else if (shifted < SatMin) begin
      result = SatMin[SampleW-1:0];
    end else begin
      result = shifted[SampleW-1:0];
    end
  end

endmodule

@@ rtl/sensor_axis_alignment.sv @@
// Top level of the sensor axis alignment pipeline with its configuration registers.
`timescale 1ns / 1ps
// Four register stages: an item accepted with start strobes out_valid once it has passed the
// remap, products, row sum and output registers, where the receiver takes it.
// Throughput: one item per cycle; busy stays low, so start is taken every cycle, and the
// receiver cannot stall. Stages: remap, products, row sum, clamp into the output register.
// Reset (synchronous, rst_n low) empties the pipeline, disables board alignment and
// loads the identity matrix into the three row registers.

module sensor_axis_alignment (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  saa_pkg::sample_t              in_sample_x,
  input  saa_pkg::sample_t              in_sample_y,
  input  saa_pkg::sample_t              in_sample_z,
  input  logic [saa_pkg::OrientW-1:0]   in_orientation,
  output logic                          out_valid,
  output saa_pkg::sample_t              out_aligned_x,
  output saa_pkg::sample_t              out_aligned_y,
  output saa_pkg::sample_t              out_aligned_z,
  input  logic                          cfg_we,
  input  logic [saa_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [saa_pkg::RowW-1:0]      cfg_wdata
);

  logic                        align_en_r;
  logic [saa_pkg::RowW-1:0]    row_x_r, row_y_r, row_z_r;

  saa_pkg::vec_t               s1_vec;
  saa_pkg::vec_t               s2_vec_r, s3_vec_r;
  saa_pkg::sample_t            mat_x, mat_y, mat_z;
  logic                        out_valid_r;
  saa_pkg::sample_t            out_x_r, out_y_r, out_z_r;
  saa_pkg::sample_t            out_x_nxt, out_y_nxt, out_z_nxt;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_en_r <= 1'b0;
      row_x_r    <= saa_pkg::ROW_X_RESET;
      row_y_r    <= saa_pkg::ROW_Y_RESET;
      row_z_r    <= saa_pkg::ROW_Z_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        saa_pkg::CFG_ALIGN_EN: align_en_r <= cfg_wdata[0];
        saa_pkg::CFG_ROW_X:    row_x_r <= cfg_wdata;
        saa_pkg::CFG_ROW_Y:    row_y_r <= cfg_wdata;
        saa_pkg::CFG_ROW_Z:    row_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage one: orientation remap.
  saa_remap u_remap (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_x      (in_sample_x),
    .in_y      (in_sample_y),
    .in_z      (in_sample_z),
    .in_orient (in_orientation),
    .out_vec   (s1_vec)
  );

  // Stages two and three: one unit per matrix row.
  saa_row u_row_x (
    .clk (clk), .coef_row (row_x_r),
    .vec_x (s1_vec.x), .vec_y (s1_vec.y), .vec_z (s1_vec.z),
    .result (mat_x)
  );

  saa_row u_row_y (
    .clk (clk), .coef_row (row_y_r),
    .vec_x (s1_vec.x), .vec_y (s1_vec.y), .vec_z (s1_vec.z),
    .result (mat_y)
  );

  saa_row u_row_z (
    .clk (clk), .coef_row (row_z_r),
    .vec_x (s1_vec.x), .vec_y (s1_vec.y), .vec_z (s1_vec.z),
    .result (mat_z)
  );

  // Carry the remapped vector and valid bit alongside the row units.
  // Only the valid bits reset; the vector fields simply follow.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vec_r.valid <= 1'b0;
      s3_vec_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      s2_vec_r.valid <= s1_vec.valid;
      s3_vec_r.valid <= s2_vec_r.valid;
      out_valid_r    <= s3_vec_r.valid;
    end
    s2_vec_r.x <= s1_vec.x;
    s2_vec_r.y <= s1_vec.y;
    s2_vec_r.z <= s1_vec.z;
    s3_vec_r.x <= s2_vec_r.x;
    s3_vec_r.y <= s2_vec_r.y;
    s3_vec_r.z <= s2_vec_r.z;
  end

  // Stage four: pick the matrix result or the plain remapped vector.
  always_comb begin
    if (align_en_r) begin
      out_x_nxt = mat_x;
      out_y_nxt = mat_y;
      out_z_nxt = mat_z;
    end else begin
      out_x_nxt = s3_vec_r.x;
      out_y_nxt = s3_vec_r.y;
      out_z_nxt = s3_vec_r.z;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    out_z_r <= out_z_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_aligned_x = out_x_r;
  assign out_aligned_y = out_y_r;
  assign out_aligned_z = out_z_r;

endmodule

@@ tb/sensor_axis_alignment_test.sv @@
// Self-checking testbench for the sensor axis alignment block: remapping, matrix and saturation.
`timescale 1ns / 1ps

module sensor_axis_alignment_test;

  localparam time ClkPeriod = 4ns;
  localparam int ResetCycles = 7;
  localparam int PipeDepth = 4;
  localparam int DrainSlack = 2 * PipeDepth;
  localparam int IdleLimit = 200;
  localparam int NumBlocks = 13;
  localparam int BlockItems = 150;
  localparam longint CoefScale = longint'(1) << saa_pkg::CoefFracBits;
  localparam saa_pkg::sample_t SampleMax = 16'sh7FFF;
  localparam saa_pkg::sample_t SampleMin = 16'sh8000;

  // Named register settings used by the directed table and the random blocks.
  typedef enum {
    SET_POWER_ON,
    SET_IDENTITY_ON,
    SET_PLUS_MAX,
    SET_MINUS_MAX,
    SET_UNIT_STEP,
    SET_BYPASS_WIDE,
    SET_RANDOM
  } setting_t;

  typedef struct packed {
    saa_pkg::sample_t x;
    saa_pkg::sample_t y;
    saa_pkg::sample_t z;
  } axes_t;

  // One directed item; the expected axes are only meaningful when known is set.
  typedef struct {
    setting_t                    setting;
    int                          sx;
    int                          sy;
    int                          sz;
    logic [saa_pkg::OrientW-1:0] orient;
    bit                          known;
    int                          ex;
    int                          ey;
    int                          ez;
  } stim_row_t;

  localparam int NumDirected = 22;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  saa_pkg::sample_t            in_sample_x = '0;
  saa_pkg::sample_t            in_sample_y = '0;
  saa_pkg::sample_t            in_sample_z = '0;
  logic [saa_pkg::OrientW-1:0] in_orientation = saa_pkg::ORIENT_CW0;
  logic                        out_valid;
  saa_pkg::sample_t            out_aligned_x;
  saa_pkg::sample_t            out_aligned_y;
  saa_pkg::sample_t            out_aligned_z;
  logic                        cfg_we = 1'b0;
  logic [saa_pkg::CfgIdxW-1:0] cfg_index = saa_pkg::CFG_ALIGN_EN;
  logic [saa_pkg::RowW-1:0]    cfg_wdata = '0;

  // Local copy of the register file, starting from the power-on values.
  logic                        align_en = 1'b0;
  logic [saa_pkg::RowW-1:0]    row_coef [3] = '{saa_pkg::ROW_X_RESET, saa_pkg::ROW_Y_RESET,
                                                saa_pkg::ROW_Z_RESET};

  axes_t pending_axes [$];
  int    items_sent = 0;
  int    results_checked = 0;
  int    mismatch_count = 0;
  int    reg_writes = 0;
  int    settings_applied = 0;
  int    stall_cycles = 0;

  stim_row_t directed_rows [NumDirected] = '{
    // Power-on registers: alignment off, pure remapping of every orientation.
    '{SET_POWER_ON, 1, 2, 3, saa_pkg::ORIENT_CW0, 1'b1, 1, 2, 3},
    '{SET_POWER_ON, 1, 2, 3, saa_pkg::ORIENT_CW90, 1'b1, 2, -1, 3},
    '{SET_POWER_ON, 1, 2, 3, saa_pkg::ORIENT_CW180, 1'b1, -1, -2, 3},
    '{SET_POWER_ON, 1, 2, 3, saa_pkg::ORIENT_CW270, 1'b1, -2, 1, 3},
    '{SET_POWER_ON, 1, 2, 3, saa_pkg::ORIENT_CW0_FLIP, 1'b1, -1, 2, -3},
    '{SET_POWER_ON, 1, 2, 3, saa_pkg::ORIENT_CW90_FLIP, 1'b1, 2, 1, -3},
    '{SET_POWER_ON, 1, 2, 3, saa_pkg::ORIENT_CW180_FLIP, 1'b1, 1, -2, -3},
    '{SET_POWER_ON, 1, 2, 3, saa_pkg::ORIENT_CW270_FLIP, 1'b1, -2, -1, -3},
    // Negating the most negative sample clamps to the most positive one.
    '{SET_POWER_ON, -32768, -32768, -32768, saa_pkg::ORIENT_CW180_FLIP, 1'b1,
      -32768, 32767, 32767},
    '{SET_POWER_ON, -32768, -32768, -32768, saa_pkg::ORIENT_CW270_FLIP, 1'b1,
      32767, 32767, 32767},
    '{SET_POWER_ON, 32767, -32768, 0, saa_pkg::ORIENT_CW90, 1'b1, -32768, -32767, 0},
    '{SET_POWER_ON, 32767, 32767, 32767, saa_pkg::ORIENT_CW0_FLIP, 1'b1,
      -32767, 32767, -32767},
    // Identity matrix with alignment on passes the remapped axes through.
    '{SET_IDENTITY_ON, -32768, 32767, -1, saa_pkg::ORIENT_CW0, 1'b1, -32768, 32767, -1},
    '{SET_IDENTITY_ON, 12345, -23456, 7, saa_pkg::ORIENT_CW180, 1'b1, -12345, 23456, 7},
    // Largest coefficients drive the row sums into saturation.
    '{SET_PLUS_MAX, 32767, 32767, 32767, saa_pkg::ORIENT_CW0, 1'b0, 0, 0, 0},
    '{SET_PLUS_MAX, -32768, -32768, -32768, saa_pkg::ORIENT_CW0, 1'b0, 0, 0, 0},
    '{SET_PLUS_MAX, -32768, -32768, -32768, saa_pkg::ORIENT_CW270_FLIP, 1'b0, 0, 0, 0},
    '{SET_MINUS_MAX, 32767, 32767, 32767, saa_pkg::ORIENT_CW0, 1'b0, 0, 0, 0},
    '{SET_MINUS_MAX, -32768, -32768, -32768, saa_pkg::ORIENT_CW0, 1'b0, 0, 0, 0},
    // Tiny coefficients show truncation toward zero on negative sums.
    '{SET_UNIT_STEP, -1, 1, -16383, saa_pkg::ORIENT_CW0, 1'b0, 0, 0, 0},
    '{SET_UNIT_STEP, -16385, 0, 0, saa_pkg::ORIENT_CW0, 1'b0, 0, 0, 0},
    // Enable written with a wide value whose low bit is clear: alignment off.
    '{SET_BYPASS_WIDE, 100, -200, 300, saa_pkg::ORIENT_CW90, 1'b1, -200, -100, 300}
  };

  sensor_axis_alignment uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_sample_x   (in_sample_x),
    .in_sample_y   (in_sample_y),
    .in_sample_z   (in_sample_z),
    .in_orientation(in_orientation),
    .out_valid     (out_valid),
    .out_aligned_x (out_aligned_x),
    .out_aligned_y (out_aligned_y),
    .out_aligned_z (out_aligned_z),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Negation that clamps the most negative sample.
  function automatic saa_pkg::sample_t negate_clamped(input saa_pkg::sample_t v);
    return (v == SampleMin) ? SampleMax : saa_pkg::sample_t'(-v);
  endfunction

  // One matrix row: exact sum of products, truncated toward zero, then clamped.
  function automatic saa_pkg::sample_t apply_row(input logic [saa_pkg::RowW-1:0] row,
                                                 input axes_t v);
    longint           acc;
    longint           quot;
    saa_pkg::sample_t res;
    acc = longint'(saa_pkg::sample_t'(row[15:0])) * longint'(v.x)
        + longint'(saa_pkg::sample_t'(row[31:16])) * longint'(v.y)
        + longint'(saa_pkg::sample_t'(row[47:32])) * longint'(v.z);
    quot = acc / CoefScale;
    if (quot > longint'(SampleMax)) begin
      res = SampleMax;
    end else if (quot < longint'(SampleMin)) begin
      res = SampleMin;
    end else begin
      res = saa_pkg::sample_t'(quot);
    end
    return res;
  endfunction

  // Expected aligned axes for one sample under the current registers.
  function automatic axes_t align_axes(input saa_pkg::sample_t sx, input saa_pkg::sample_t sy,
                                       input saa_pkg::sample_t sz,
                                       input logic [saa_pkg::OrientW-1:0] o);
    axes_t m;
    axes_t r;
    case (o)
      saa_pkg::ORIENT_CW0:        m = '{sx, sy, sz};
      saa_pkg::ORIENT_CW90:       m = '{sy, negate_clamped(sx), sz};
      saa_pkg::ORIENT_CW180:      m = '{negate_clamped(sx), negate_clamped(sy), sz};
      saa_pkg::ORIENT_CW270:      m = '{negate_clamped(sy), sx, sz};
      saa_pkg::ORIENT_CW0_FLIP:   m = '{negate_clamped(sx), sy, negate_clamped(sz)};
      saa_pkg::ORIENT_CW90_FLIP:  m = '{sy, sx, negate_clamped(sz)};
      saa_pkg::ORIENT_CW180_FLIP: m = '{sx, negate_clamped(sy), negate_clamped(sz)};
      default: m = '{negate_clamped(sy), negate_clamped(sx), negate_clamped(sz)};
    endcase
    if (align_en) begin
      r.x = apply_row(row_coef[0], m);
      r.y = apply_row(row_coef[1], m);
      r.z = apply_row(row_coef[2], m);
    end else begin
      r = m;
    end
    return r;
  endfunction

  // Random sample, biased toward the extremes and values near zero.
  function automatic saa_pkg::sample_t pick_sample();
    logic [31:0]      r;
    saa_pkg::sample_t s;
    r = $urandom();
    case ($urandom_range(0, 9))
      0:       s = SampleMin;
      1:       s = SampleMax;
      2:       s = saa_pkg::sample_t'(int'($urandom_range(0, 4)) - 2);
      default: s = saa_pkg::sample_t'(r[15:0]);
    endcase
    return s;
  endfunction

  // One register write; the local copy follows at the edge that performs it.
  task automatic write_reg(input logic [saa_pkg::CfgIdxW-1:0] idx,
                           input logic [saa_pkg::RowW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      saa_pkg::CFG_ALIGN_EN: align_en = value[0];
      saa_pkg::CFG_ROW_X:    row_coef[0] = value;
      saa_pkg::CFG_ROW_Y:    row_coef[1] = value;
      default:               row_coef[2] = value;
    endcase
    reg_writes++;
  endtask

  // Loads one register setting; the block must be idle when this is called.
  task automatic apply_setting(input setting_t s);
    logic [saa_pkg::RowW-1:0] val;
    int                       k;
    int                       j;
    case (s)
      SET_POWER_ON: begin
      end
      SET_IDENTITY_ON: begin
        write_reg(saa_pkg::CFG_ALIGN_EN, 48'h1);
        write_reg(saa_pkg::CFG_ROW_X, saa_pkg::ROW_X_RESET);
        write_reg(saa_pkg::CFG_ROW_Y, saa_pkg::ROW_Y_RESET);
        write_reg(saa_pkg::CFG_ROW_Z, saa_pkg::ROW_Z_RESET);
      end
      SET_PLUS_MAX: begin
        write_reg(saa_pkg::CFG_ALIGN_EN, 48'h1);
        write_reg(saa_pkg::CFG_ROW_X, {3{16'h7FFF}});
        write_reg(saa_pkg::CFG_ROW_Y, {3{16'h7FFF}});
        write_reg(saa_pkg::CFG_ROW_Z, {3{16'h7FFF}});
      end
      SET_MINUS_MAX: begin
        write_reg(saa_pkg::CFG_ALIGN_EN, 48'h1);
        write_reg(saa_pkg::CFG_ROW_X, {3{16'h8000}});
        write_reg(saa_pkg::CFG_ROW_Y, {3{16'h8000}});
        write_reg(saa_pkg::CFG_ROW_Z, {3{16'h8000}});
      end
      SET_UNIT_STEP: begin
        write_reg(saa_pkg::CFG_ALIGN_EN, 48'h1);
        write_reg(saa_pkg::CFG_ROW_X, 48'h0000_0000_0001);
        write_reg(saa_pkg::CFG_ROW_Y, 48'h0000_FFFF_0000);
        write_reg(saa_pkg::CFG_ROW_Z, 48'h0001_0001_0001);
      end
      SET_BYPASS_WIDE: begin
        write_reg(saa_pkg::CFG_ALIGN_EN, 48'hFFFF_FFFF_FFFE);
      end
      default: begin
        // Wide random enable value; alignment on in three settings of four.
        val = {16'($urandom()), $urandom()};
        val[0] = ($urandom_range(0, 3) != 0);
        write_reg(saa_pkg::CFG_ALIGN_EN, val);
        for (k = 0; k < 3; k++) begin
          case ($urandom_range(0, 4))
            0: val = {3{16'h7FFF}};
            1: val = {3{16'h8000}};
            2: val = {16'($urandom()), $urandom()};
            3: begin
              val = '0;
              val[16 * $urandom_range(0, 2) +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
            end
            default: begin
              for (j = 0; j < 3; j++) begin
                val[16 * j +: 16] = 16'(int'($urandom_range(0, 32768)) - 16384);
              end
            end
          endcase
          write_reg(saa_pkg::CfgIdxW'(k + 1), val);
        end
      end
    endcase
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Presents one item and holds it until the block takes it.
  task automatic send_item(input saa_pkg::sample_t sx, input saa_pkg::sample_t sy,
                           input saa_pkg::sample_t sz,
                           input logic [saa_pkg::OrientW-1:0] o, input axes_t want);
    start <= 1'b1;
    in_sample_x <= sx;
    in_sample_y <= sy;
    in_sample_z <= sz;
    in_orientation <= o;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_axes.push_back(want);
    items_sent++;
  endtask

  // Waits until every expected result has come back.
  task automatic wait_drained();
    do @(posedge clk); while (pending_axes.size() != 0);
  endtask

  // Result checker: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    axes_t got;
    axes_t want;
    if (rst_n && out_valid) begin
      got = '{out_aligned_x, out_aligned_y, out_aligned_z};
      if (pending_axes.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result (%0d, %0d, %0d) with nothing expected",
                 $time, got.x, got.y, got.z);
      end else begin
        want = pending_axes.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatch_count++;
          $display("%0t: mismatch: expected (%0d, %0d, %0d), got (%0d, %0d, %0d)",
                   $time, want.x, want.y, want.z, got.x, got.y, got.z);
        end
      end
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus: directed table, then random blocks with their own settings and idling.
  initial begin
    setting_t                    current;
    axes_t                       want;
    saa_pkg::sample_t            sx;
    saa_pkg::sample_t            sy;
    saa_pkg::sample_t            sz;
    logic [saa_pkg::OrientW-1:0] o;
    int                          blk;
    int                          n;
    int                          idle_pct;

    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    current = SET_POWER_ON;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].setting != current) begin
        start <= 1'b0;
        wait_drained();
        apply_setting(directed_rows[i].setting);
        current = directed_rows[i].setting;
      end
      sx = saa_pkg::sample_t'(directed_rows[i].sx);
      sy = saa_pkg::sample_t'(directed_rows[i].sy);
      sz = saa_pkg::sample_t'(directed_rows[i].sz);
      o = directed_rows[i].orient;
      if (directed_rows[i].known) begin
        want = '{saa_pkg::sample_t'(directed_rows[i].ex),
                 saa_pkg::sample_t'(directed_rows[i].ey),
                 saa_pkg::sample_t'(directed_rows[i].ez)};
      end else begin
        want = align_axes(sx, sy, sz, o);
      end
      send_item(sx, sy, sz, o, want);
    end

    // Each random block drains, loads a fresh setting and runs one idling pattern.
    for (blk = 0; blk < NumBlocks; blk++) begin
      start <= 1'b0;
      wait_drained();
      apply_setting(SET_RANDOM);
      case (blk % 4)
        1:       idle_pct = 60;
        3:       idle_pct = 26;
        default: idle_pct = 0;
      endcase
      for (n = 0; n < BlockItems; n++) begin
        // Each cycle the sender stays idle with the chosen probability.
        while ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          @(posedge clk);
        end
        sx = pick_sample();
        sy = pick_sample();
        sz = pick_sample();
        o = saa_pkg::OrientW'($urandom_range(0, 7));
        send_item(sx, sy, sz, o, align_axes(sx, sy, sz, o));
      end
    end

    start <= 1'b0;
    wait_drained();
    repeat (DrainSlack) @(posedge clk);

    $display("Run covered %0d items (all orientations, clamped negation, saturated and",
             items_sent);
    $display("truncated row sums) and %0d results over %0d settings (%0d register writes).",
             results_checked, settings_applied, reg_writes);
    if (mismatch_count == 0 && pending_axes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/saa_pkg.sv
rtl/saa_remap.sv
rtl/saa_row.sv
rtl/sensor_axis_alignment.sv
tb/sensor_axis_alignment_test.sv
